>>> rtl/hzd_pkg.sv
// Shared types and character codes for the HZ text decoder.
// Used by hzd_decode, hzd_burst_buf and the top level hz_text_decoder.
package hzd_pkg;

  localparam logic [7:0] ChTilde  = 8'h7E;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] HiBit    = 8'h80;

  // Largest number of decoded bytes that one encoded byte can cause.
  localparam int unsigned MaxBurst = 3;
  localparam int unsigned CntW     = $clog2(MaxBurst + 1);

  typedef enum logic [2:0] {
    MODE_ASCII  = 3'd0,
    MODE_ATILDE = 3'd1,
    MODE_GB     = 3'd2,
    MODE_GTILDE = 3'd3,
    MODE_HELD   = 3'd4
  } mode_e;

  // Decoded bytes for one input beat, first byte in slot 0.
  typedef struct packed {
    logic [CntW-1:0]                cnt;
    logic [MaxBurst-1:0][7:0]       bytes;
  } burst_t;

endpackage

>>> rtl/hzd_decode.sv
// Escape and mode tracking for the HZ text decoder.
// Holds the decode mode and the pending GB lead byte; depends on hzd_pkg.
module hzd_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    in_byte_i,
  output hzd_pkg::burst_t burst_o
);
  import hzd_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] held_q, held_d;
  burst_t     burst;

  // Next mode and held lead byte.
  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    unique case (mode_q)
      MODE_ATILDE: begin
        mode_d = MODE_ASCII;
        if (in_byte_i == ChLbrace) begin
          mode_d = MODE_GB;
        end
      end
      MODE_GB: begin
        if (in_byte_i == ChTilde) begin
          mode_d = MODE_GTILDE;
        end else if (in_byte_i != ChCr && in_byte_i != ChLf) begin
          held_d = in_byte_i;
          mode_d = MODE_HELD;
        end
      end
      MODE_GTILDE: begin
        mode_d = MODE_GB;
        if ((in_byte_i & HiBit) != 8'h00) begin
          held_d = in_byte_i;
          mode_d = MODE_HELD;
        end else if (in_byte_i == ChRbrace) begin
          mode_d = MODE_ASCII;
        end
      end
      MODE_HELD: begin
        mode_d = MODE_GB;
        // A high byte after a low lead byte ends the pair and starts a new one.
        if ((held_q & HiBit) == 8'h00 && (in_byte_i & HiBit) != 8'h00) begin
          held_d = in_byte_i;
          mode_d = MODE_HELD;
        end
      end
      default: begin
        mode_d = MODE_ASCII;
        if (in_byte_i == ChTilde) begin
          mode_d = MODE_ATILDE;
        end
      end
    endcase
  end

  // Decoded bytes for the current input beat.
  always_comb begin
    burst = '0;
    unique case (mode_q)
      MODE_ATILDE: begin
        if (in_byte_i == ChTilde || in_byte_i == ChCr) begin
          burst.cnt      = CntW'(1);
          burst.bytes[0] = ChTilde;
        end else if (in_byte_i == ChLf) begin
          burst.cnt = '0;
        end else if (in_byte_i == ChLbrace) begin
          burst.cnt = '0;
        end else begin
          burst.cnt      = CntW'(2);
          burst.bytes[0] = ChTilde;
          burst.bytes[1] = in_byte_i;
        end
      end
      MODE_GB: begin
        if (in_byte_i == ChLf) begin
          burst.cnt      = CntW'(2);
          burst.bytes[0] = ChCr;
          burst.bytes[1] = ChLf;
        end
      end
      MODE_GTILDE: begin
        if ((in_byte_i & HiBit) != 8'h00) begin
          burst.cnt      = CntW'(1);
          burst.bytes[0] = ChTilde;
        end else if (in_byte_i == ChCr) begin
          burst.cnt      = CntW'(1);
          burst.bytes[0] = ChTilde;
        end else if (in_byte_i == ChLf) begin
          burst.cnt      = CntW'(3);
          burst.bytes[0] = ChTilde;
          burst.bytes[1] = ChCr;
          burst.bytes[2] = ChLf;
        end else if (in_byte_i == ChRbrace) begin
          burst.cnt = '0;
        end else begin
          burst.cnt      = CntW'(2);
          burst.bytes[0] = ChTilde;
          burst.bytes[1] = in_byte_i;
        end
      end
      MODE_HELD: begin
        if (in_byte_i == ChCr) begin
          burst.cnt      = CntW'(1);
          burst.bytes[0] = held_q;
        end else if (in_byte_i == ChLf) begin
          burst.cnt      = CntW'(3);
          burst.bytes[0] = held_q;
          burst.bytes[1] = ChCr;
          burst.bytes[2] = ChLf;
        end else if ((held_q & HiBit) == 8'h00 && (in_byte_i & HiBit) != 8'h00) begin
          burst.cnt      = CntW'(1);
          burst.bytes[0] = held_q;
        end else begin
          burst.cnt      = CntW'(2);
          burst.bytes[0] = held_q | HiBit;
          burst.bytes[1] = in_byte_i | HiBit;
        end
      end
      default: begin
        if (in_byte_i != ChTilde) begin
          burst.cnt      = CntW'(1);
          burst.bytes[0] = in_byte_i;
        end
      end
    endcase
  end

  assign burst_o = burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ASCII;
      held_q <= 8'h00;
    end else if (take_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

endmodule

>>> rtl/hzd_burst_buf.sv
// Result register for the HZ text decoder: holds the bytes of one input beat
// and hands them out one per output beat. Depends on hzd_pkg.
module hzd_burst_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  hzd_pkg::burst_t burst_i,
  output logic            can_load_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_run_o
);
  import hzd_pkg::*;

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [MaxBurst-1:0][7:0] bytes_q, bytes_d;
  logic                     pop;

  assign out_valid_o   = cnt_q != '0;
  assign out_byte_o    = bytes_q[0];
  assign last_of_run_o = cnt_q == CntW'(1);
  assign pop           = out_valid_o && out_ready_i;

  // A new burst may load once the current one is gone or leaves this cycle.
  assign can_load_o = (cnt_q == '0) || (last_of_run_o && out_ready_i);

  always_comb begin
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    if (load_i) begin
      cnt_d   = burst_i.cnt;
      bytes_d = burst_i.bytes;
    end else if (pop) begin
      cnt_d   = cnt_q - CntW'(1);
      bytes_d = {8'h00, bytes_q[MaxBurst-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule

>>> rtl/hz_text_decoder.sv
// HZ text decoder: takes one encoded byte per input beat and delivers zero to
// three decoded bytes as output beats, last_of_run_o marking the final one of
// each input byte. A new input byte is taken every cycle as long as each one
// decodes to at most one byte; an input that yields two or three bytes holds
// in_ready_o low while the result register drains, since that register hands
// out one byte per cycle. Output stalls stall the input the same way. ASCII/GB
// mode and any pending GB lead byte carry over from message to message; apart
// from the ~} escape, only reset returns the decoder to ASCII mode.
// Depends on hzd_pkg, hzd_decode and hzd_burst_buf.
module hz_text_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import hzd_pkg::*;

  burst_t burst;
  logic   take;

  assign take = in_valid_i && in_ready_o;

  hzd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_byte_i (in_byte_i),
    .burst_o   (burst)
  );

  hzd_burst_buf u_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take),
    .burst_i       (burst),
    .can_load_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
